/* src/cc20_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the ChaCha20 stream XOR block.
package cc20_pkg;

	localparam logic [31:0] SIGMA0 = 32'h61707865;
	localparam logic [31:0] SIGMA1 = 32'h3320646e;
	localparam logic [31:0] SIGMA2 = 32'h79622d32;
	localparam logic [31:0] SIGMA3 = 32'h6b206574;

	localparam int ROUNDS        = 20;
	localparam int DOUBLE_ROUNDS = ROUNDS / 2;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_KEY01      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_KEY23      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY45      = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY67      = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_LOW  = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_NONCE_HIGH = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_START_CTR  = 3'd6;

	typedef logic [15:0][31:0] block_t;
	typedef logic [3:0][31:0]  quad_t;

	typedef struct packed {
		logic       first_of_message;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
	} out_item_t;

	typedef struct packed {
		logic start;
	} core_req_t;

	typedef struct packed {
		logic busy;
		logic done;
	} core_stat_t;

endpackage

/* src/cc20_stream_if.sv */
`timescale 1ns / 1ps
// Valid/ready stream channel carrying one payload item per transaction.
interface cc20_stream_if #(
	parameter type T = logic
) ();
	logic valid;
	logic ready;
	T     payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

/* src/cc20_qr_unit.sv */
`timescale 1ns / 1ps
// Half of a ChaCha quarter round: two add/xor/rotate steps.
module cc20_qr_unit (
	input  logic           second_half,
	input  cc20_pkg::quad_t quad_in,
	output cc20_pkg::quad_t quad_out
);
	import cc20_pkg::*;

	logic [31:0] a1, c1, dx, bx, d1, b1;

	always_comb begin
		a1 = quad_in[0] + quad_in[1];
		dx = quad_in[3] ^ a1;
		// rotate by 8 in the second half, 16 in the first
		d1 = second_half ? {dx[23:0], dx[31:24]} : {dx[15:0], dx[31:16]};
		c1 = quad_in[2] + d1;
		bx = quad_in[1] ^ c1;
		// rotate by 7 in the second half, 12 in the first
		b1 = second_half ? {bx[24:0], bx[31:25]} : {bx[19:0], bx[31:20]};
		quad_out[0] = a1;
		quad_out[1] = b1;
		quad_out[2] = c1;
		quad_out[3] = d1;
	end
endmodule

/* src/cc20_core.sv */
`timescale 1ns / 1ps
// Block generator: one shared half quarter-round unit stepped over the state.
module cc20_core (
	input  logic                clk,
	input  logic                arst_n,
	input  cc20_pkg::core_req_t req,
	output cc20_pkg::core_stat_t stat,
	input  cc20_pkg::block_t    init_w,
	input  logic [5:0]          pos,
	output logic [7:0]          ks_byte
);
	import cc20_pkg::*;

	localparam logic [1:0] PH_IDLE  = 2'd0;
	localparam logic [1:0] PH_ROUND = 2'd1;
	localparam logic [1:0] PH_FINAL = 2'd2;

	localparam logic [3:0] DR_LAST = 4'(DOUBLE_ROUNDS - 1);

	logic [1:0] phase_q;
	logic       half_q;
	logic [1:0] qr_q;
	logic       diag_q;
	logic [3:0] dr_q;
	logic [3:0] k_q;
	block_t     w_q;
	block_t     w_d;
	quad_t      qin, qout;

	assign qin[0] = w_q[0];
	assign qin[1] = w_q[4];
	assign qin[2] = w_q[8];
	assign qin[3] = w_q[12];

	cc20_qr_unit u_qr (
		.second_half (half_q),
		.quad_in     (qin),
		.quad_out    (qout)
	);

	assign stat.busy = (phase_q != PH_IDLE);
	assign stat.done = (phase_q == PH_FINAL) && (k_q == 4'hF);

	logic [31:0] ks_word;
	assign ks_word = w_q[pos[5:2]];
	assign ks_byte = ks_word[{pos[1:0], 3'b000} +: 8];

	always_comb begin
		logic [1:0] amt;
		logic [1:0] src;
		amt = 2'd0;
		src = 2'd0;
		w_d = w_q;
		case (phase_q)
			PH_IDLE: begin
				if (req.start) begin
					w_d = init_w;
				end
			end
			PH_ROUND: begin
				if (!half_q) begin
					w_d[0]  = qout[0];
					w_d[4]  = qout[1];
					w_d[8]  = qout[2];
					w_d[12] = qout[3];
				end else begin
					// write back column 0, then rotate rows; on the last column the
					// rotation also moves between column and diagonal layout
					for (int r = 0; r < 4; r++) begin
						if (qr_q != 2'd3) begin
							amt = 2'd1;
						end else if (!diag_q) begin
							amt = 2'(r + 1);
						end else begin
							amt = 2'(5 - r);
						end
						for (int j = 0; j < 4; j++) begin
							src = 2'(j) + amt;
							if (src == 2'd0) begin
								w_d[4*r+j] = qout[r];
							end else begin
								w_d[4*r+j] = w_q[4*r+int'(src)];
							end
						end
					end
				end
			end
			PH_FINAL: begin
				// shift the words past one adder, adding the initial word
				for (int i = 0; i < 15; i++) begin
					w_d[i] = w_q[i+1];
				end
				w_d[15] = w_q[0] + init_w[k_q];
			end
			default: begin
				w_d = w_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		w_q <= w_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			half_q  <= 1'b0;
			qr_q    <= 2'd0;
			diag_q  <= 1'b0;
			dr_q    <= 4'd0;
			k_q     <= 4'd0;
		end else begin
			case (phase_q)
				PH_IDLE: begin
					if (req.start) begin
						phase_q <= PH_ROUND;
						half_q  <= 1'b0;
						qr_q    <= 2'd0;
						diag_q  <= 1'b0;
						dr_q    <= 4'd0;
					end
				end
				PH_ROUND: begin
					half_q <= ~half_q;
					if (half_q) begin
						qr_q <= qr_q + 2'd1;
						if (qr_q == 2'd3) begin
							diag_q <= ~diag_q;
							if (diag_q) begin
								dr_q <= dr_q + 4'd1;
								if (dr_q == DR_LAST) begin
									phase_q <= PH_FINAL;
									k_q     <= 4'd0;
								end
							end
						end
					end
				end
				PH_FINAL: begin
					k_q <= k_q + 4'd1;
					if (k_q == 4'hF) begin
						phase_q <= PH_IDLE;
					end
				end
				default: begin
					phase_q <= PH_IDLE;
				end
			endcase
		end
	end
endmodule

/* src/chacha20_stream_xor_unit.sv */
`timescale 1ns / 1ps
// ChaCha20 stream XOR unit: one message byte in, one transformed byte out.
// A byte whose keystream block is already held is XORed straight into the output register;
// a byte that needs a new block first passes the load state, 20 rounds at one half quarter
// round per cycle, the final add, the emit state and then the output register.
// Throughput: one byte per cycle within a block while the output is not stalled.
// Reset clears control state, position and counter; start counter resets to 1.
module chacha20_stream_xor_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	cc20_stream_if.sink                         in_stream,
	cc20_stream_if.source                       out_stream,
	input  logic                                cfg_we,
	input  logic [cc20_pkg::CFG_IDX_W-1:0]      cfg_idx,
	input  logic [cc20_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import cc20_pkg::*;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_LOAD = 2'd1;
	localparam logic [1:0] ST_GEN  = 2'd2;
	localparam logic [1:0] ST_EMIT = 2'd3;

	logic [63:0] key01_q, key23_q, key45_q, key67_q, nonce_low_q;
	logic [31:0] nonce_high_q, start_ctr_q;

	logic [1:0]  state_q;
	logic [31:0] ctr_q;
	logic [5:0]  pos_q;
	logic        ksv_q;
	logic [7:0]  data_q;
	logic        out_valid_q;
	logic [7:0]  out_byte_q;

	core_req_t   core_req;
	core_stat_t  core_stat;
	block_t      init_w;
	logic [7:0]  ks_byte;

	in_item_t    in_item;
	logic        out_free;
	logic        accept;
	logic        emit_now;
	logic        emit_late;
	logic [5:0]  pos_inc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key01_q      <= '0;
			key23_q      <= '0;
			key45_q      <= '0;
			key67_q      <= '0;
			nonce_low_q  <= '0;
			nonce_high_q <= '0;
			start_ctr_q  <= 32'd1;
		end else if (cfg_we) begin
			case (cfg_idx)
				REG_KEY01:      key01_q      <= cfg_data;
				REG_KEY23:      key23_q      <= cfg_data;
				REG_KEY45:      key45_q      <= cfg_data;
				REG_KEY67:      key67_q      <= cfg_data;
				REG_NONCE_LOW:  nonce_low_q  <= cfg_data;
				REG_NONCE_HIGH: nonce_high_q <= cfg_data[31:0];
				REG_START_CTR:  start_ctr_q  <= cfg_data[31:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		init_w[0]  = SIGMA0;
		init_w[1]  = SIGMA1;
		init_w[2]  = SIGMA2;
		init_w[3]  = SIGMA3;
		init_w[4]  = key01_q[31:0];
		init_w[5]  = key01_q[63:32];
		init_w[6]  = key23_q[31:0];
		init_w[7]  = key23_q[63:32];
		init_w[8]  = key45_q[31:0];
		init_w[9]  = key45_q[63:32];
		init_w[10] = key67_q[31:0];
		init_w[11] = key67_q[63:32];
		init_w[12] = ctr_q;
		init_w[13] = nonce_low_q[31:0];
		init_w[14] = nonce_low_q[63:32];
		init_w[15] = nonce_high_q;
	end

	assign core_req.start = (state_q == ST_LOAD);

	cc20_core u_core (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (core_req),
		.stat    (core_stat),
		.init_w  (init_w),
		.pos     (pos_q),
		.ks_byte (ks_byte)
	);

	assign in_item  = in_stream.payload;
	assign out_free = !out_valid_q || out_stream.ready;
	assign in_stream.ready = (state_q == ST_IDLE) && out_free;
	assign accept    = in_stream.valid && in_stream.ready;
	assign emit_now  = accept && ksv_q && !in_item.first_of_message;
	assign emit_late = (state_q == ST_EMIT) && out_free;
	assign pos_inc   = pos_q + 6'd1;

	assign out_stream.valid            = out_valid_q;
	assign out_stream.payload.out_byte = out_byte_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			data_q <= in_item.data_byte;
		end
		if (emit_now) begin
			out_byte_q <= in_item.data_byte ^ ks_byte;
		end else if (emit_late) begin
			out_byte_q <= data_q ^ ks_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			ctr_q       <= '0;
			pos_q       <= '0;
			ksv_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit_now || emit_late) begin
				out_valid_q <= 1'b1;
			end else if (out_stream.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (emit_now) begin
						pos_q <= pos_inc;
						ksv_q <= (pos_inc != 6'd0);
					end else if (accept) begin
						// new block needed: restart message if flagged
						if (in_item.first_of_message) begin
							ctr_q <= start_ctr_q;
							pos_q <= '0;
						end
						ksv_q   <= 1'b0;
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					state_q <= ST_GEN;
				end
				ST_GEN: begin
					if (core_stat.done) begin
						ctr_q   <= ctr_q + 32'd1;
						ksv_q   <= 1'b1;
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_late) begin
						pos_q   <= pos_inc;
						ksv_q   <= (pos_inc != 6'd0);
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

`ifndef ASSERT_OFF
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		core_stat.busy |-> !in_stream.ready)
		else $error("input ready while block generation runs");

	a_done_to_emit: assert property (@(posedge clk) disable iff (!arst_n)
		core_stat.done |=> (state_q == ST_EMIT))
		else $error("block finished but no emit followed");

	a_emit_has_block: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (ksv_q && !core_stat.busy))
		else $error("emit without a finished keystream block");

	a_start_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		core_req.start |-> !core_stat.busy)
		else $error("block start while generator busy");
`endif
endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench for the ChaCha20 stream XOR unit, with its own ChaCha20 predictor.
module testbench;
	import cc20_pkg::*;

	localparam int WATCHDOG_LIMIT   = 3000;
	localparam int SINK_HOLD_CYCLES = 400;
	localparam int SETTLE_CYCLES    = 200;

	typedef struct packed {
		logic [7:0] data;
		logic       first;
		logic       given;
		logic [7:0] want;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	cc20_stream_if #(.T(in_item_t))  in_ch ();
	cc20_stream_if #(.T(out_item_t)) out_ch ();

	chacha20_stream_xor_unit uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_stream  (in_ch),
		.out_stream (out_ch),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predictor copy of the registers and the keystream state.
	logic [63:0] cfg_regs [7];
	block_t      ks_block;
	logic [5:0]  ks_pos;
	logic [31:0] ks_ctr;
	logic        ks_loaded;

	logic [7:0] expected_bytes [$];
	logic       offer_given;
	logic [7:0] offer_want;

	int send_idle_pct  = 0;
	int sink_stall_pct = 0;
	int hold_requests  = 0;
	int msg_left       = 0;

	int bytes_in     = 0;
	int bytes_out    = 0;
	int msgs_started = 0;
	int cfg_writes   = 0;
	int mismatches   = 0;
	int quiet_cycles = 0;

	// Keystream at key 0, nonce 0, counter 0 starts 76 b8 e0 ad.
	dir_row_t directed_rows [20] = '{
		'{8'h00, 1'b0, 1'b1, 8'h76},
		'{8'hFF, 1'b0, 1'b1, 8'h47},
		'{8'h00, 1'b0, 1'b1, 8'he0},
		'{8'hFF, 1'b0, 1'b1, 8'h52},
		'{8'h5A, 1'b1, 1'b0, 8'h00},
		'{8'h00, 1'b0, 1'b0, 8'h00},
		'{8'hFF, 1'b0, 1'b0, 8'h00},
		'{8'h80, 1'b0, 1'b0, 8'h00},
		'{8'h01, 1'b0, 1'b0, 8'h00},
		'{8'h7F, 1'b1, 1'b0, 8'h00},
		'{8'hFE, 1'b0, 1'b0, 8'h00},
		'{8'hC3, 1'b1, 1'b0, 8'h00},
		'{8'hFF, 1'b1, 1'b0, 8'h00},
		'{8'h00, 1'b1, 1'b0, 8'h00},
		'{8'hAA, 1'b0, 1'b0, 8'h00},
		'{8'h55, 1'b0, 1'b0, 8'h00},
		'{8'hFF, 1'b0, 1'b0, 8'h00},
		'{8'h00, 1'b0, 1'b0, 8'h00},
		'{8'h3C, 1'b1, 1'b0, 8'h00},
		'{8'h96, 1'b0, 1'b0, 8'h00}
	};

	function automatic logic [31:0] rotl(logic [31:0] v, int n);
		return (v << n) | (v >> (32 - n));
	endfunction

	function automatic block_t qround(block_t s, int a, int b, int c, int d);
		s[a] = s[a] + s[b]; s[d] = rotl(s[d] ^ s[a], 16);
		s[c] = s[c] + s[d]; s[b] = rotl(s[b] ^ s[c], 12);
		s[a] = s[a] + s[b]; s[d] = rotl(s[d] ^ s[a], 8);
		s[c] = s[c] + s[d]; s[b] = rotl(s[b] ^ s[c], 7);
		return s;
	endfunction

	function automatic block_t chacha_block(logic [31:0] ctr);
		block_t init_s;
		block_t work_s;
		init_s[0]  = SIGMA0;
		init_s[1]  = SIGMA1;
		init_s[2]  = SIGMA2;
		init_s[3]  = SIGMA3;
		init_s[4]  = cfg_regs[REG_KEY01][31:0];
		init_s[5]  = cfg_regs[REG_KEY01][63:32];
		init_s[6]  = cfg_regs[REG_KEY23][31:0];
		init_s[7]  = cfg_regs[REG_KEY23][63:32];
		init_s[8]  = cfg_regs[REG_KEY45][31:0];
		init_s[9]  = cfg_regs[REG_KEY45][63:32];
		init_s[10] = cfg_regs[REG_KEY67][31:0];
		init_s[11] = cfg_regs[REG_KEY67][63:32];
		init_s[12] = ctr;
		init_s[13] = cfg_regs[REG_NONCE_LOW][31:0];
		init_s[14] = cfg_regs[REG_NONCE_LOW][63:32];
		init_s[15] = cfg_regs[REG_NONCE_HIGH][31:0];
		work_s = init_s;
		for (int r = 0; r < DOUBLE_ROUNDS; r++) begin
			work_s = qround(work_s, 0, 4, 8, 12);
			work_s = qround(work_s, 1, 5, 9, 13);
			work_s = qround(work_s, 2, 6, 10, 14);
			work_s = qround(work_s, 3, 7, 11, 15);
			work_s = qround(work_s, 0, 5, 10, 15);
			work_s = qround(work_s, 1, 6, 11, 12);
			work_s = qround(work_s, 2, 7, 8, 13);
			work_s = qround(work_s, 3, 4, 9, 14);
		end
		for (int i = 0; i < 16; i++)
			work_s[i] = work_s[i] + init_s[i];
		return work_s;
	endfunction

	// Advance the keystream by one byte and return the transformed byte.
	function automatic logic [7:0] cipher_byte(in_item_t it);
		logic [31:0] word;
		if (it.first_of_message) begin
			ks_ctr    = cfg_regs[REG_START_CTR][31:0];
			ks_pos    = '0;
			ks_loaded = 1'b0;
		end
		if (!ks_loaded) begin
			ks_block  = chacha_block(ks_ctr);
			ks_ctr    = ks_ctr + 32'd1;
			ks_loaded = 1'b1;
		end
		word = ks_block[ks_pos[5:2]];
		cipher_byte = it.data_byte ^ word[8 * ks_pos[1:0] +: 8];
		ks_pos = ks_pos + 6'd1;
		if (ks_pos == 6'd0)
			ks_loaded = 1'b0;
	endfunction

	// Transaction monitor: predict on input, compare on output, watch for a hang.
	always @(posedge clk) begin
		logic [7:0] predicted;
		logic [7:0] want_byte;
		logic       moved;
		moved = 1'b0;
		if (arst_n && in_ch.valid && in_ch.ready) begin
			predicted = cipher_byte(in_ch.payload);
			expected_bytes.push_back(offer_given ? offer_want : predicted);
			bytes_in++;
			if (in_ch.payload.first_of_message)
				msgs_started++;
			moved = 1'b1;
		end
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_bytes.size() == 0) begin
				$error("out_byte with nothing expected: actual 0x%02h", out_ch.payload.out_byte);
				mismatches++;
			end else begin
				want_byte = expected_bytes.pop_front();
				if (out_ch.payload.out_byte !== want_byte) begin
					$error("out_byte mismatch: expected 0x%02h, actual 0x%02h",
						want_byte, out_ch.payload.out_byte);
					mismatches++;
				end
			end
			bytes_out++;
			moved = 1'b1;
		end
		quiet_cycles = moved ? 0 : quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog: no transaction for %0d cycles, %0d bytes still expected",
				quiet_cycles, expected_bytes.size());
			$display("** chacha20_stream_xor_unit: FAILED **");
			$finish;
		end
	end

	// Output side: random stalls plus an occasional long hold-off.
	initial begin
		int hold_served;
		int hold_left;
		hold_served  = 0;
		hold_left    = 0;
		out_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_served != hold_requests) begin
				hold_served = hold_requests;
				hold_left   = SINK_HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
		cfg_we   <= 1'b1;
		cfg_idx  <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_regs[idx] = data;
		cfg_writes++;
		@(posedge clk);
	endtask

	task automatic apply_config(logic [63:0] k01, logic [63:0] k23, logic [63:0] k45,
			logic [63:0] k67, logic [63:0] nlo, logic [31:0] nhi, logic [31:0] sctr);
		write_reg(REG_KEY01, k01);
		write_reg(REG_KEY23, k23);
		write_reg(REG_KEY45, k45);
		write_reg(REG_KEY67, k67);
		write_reg(REG_NONCE_LOW, nlo);
		write_reg(REG_NONCE_HIGH, {32'h0, nhi});
		write_reg(REG_START_CTR, {32'h0, sctr});
	endtask

	// Offer one byte; return right after the edge that takes it.
	task automatic offer(logic [7:0] data, logic first, logic given, logic [7:0] want);
		in_item_t item;
		item.data_byte        = data;
		item.first_of_message = first;
		if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
		end
		in_ch.valid   <= 1'b1;
		in_ch.payload <= item;
		offer_given   <= given;
		offer_want    <= want;
		do @(posedge clk); while (!in_ch.ready);
	endtask

	task automatic drain();
		while (expected_bytes.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Mostly whole messages with random bytes; a few stray start flags as noise.
	task automatic run_phase(int n_items, int lead_len, logic lead_first);
		int         sel;
		logic       first;
		logic [7:0] data;
		if (lead_len > 0)
			msg_left = 0;
		for (int k = 0; k < n_items; k++) begin
			first = 1'b0;
			if (k == 0 && lead_len > 0) begin
				first    = lead_first;
				msg_left = lead_len;
			end else if (msg_left <= 0) begin
				first = 1'b1;
				sel   = $urandom_range(99);
				if (sel < 60)
					msg_left = $urandom_range(40, 1);
				else if (sel < 90)
					msg_left = $urandom_range(140, 41);
				else
					msg_left = $urandom_range(260, 141);
			end else if ($urandom_range(99) < 4) begin
				first = 1'($urandom_range(1));
			end
			msg_left--;
			sel = $urandom_range(99);
			data = (sel < 8) ? 8'h00 : (sel < 16) ? 8'hFF : 8'($urandom_range(255));
			offer(data, first, 1'b0, 8'h00);
		end
		in_ch.valid <= 1'b0;
		drain();
	endtask

	initial begin
		arst_n        = 1'b0;
		in_ch.valid   = 1'b0;
		in_ch.payload = '0;
		offer_given   = 1'b0;
		offer_want    = '0;
		cfg_we        = 1'b0;
		cfg_idx       = '0;
		cfg_data      = '0;
		for (int i = 0; i < 7; i++)
			cfg_regs[i] = '0;
		cfg_regs[REG_START_CTR] = 64'd1;
		ks_block  = '0;
		ks_pos    = '0;
		ks_ctr    = '0;
		ks_loaded = 1'b0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset defaults, bytes before any start flag, short messages.
		foreach (directed_rows[i])
			offer(directed_rows[i].data, directed_rows[i].first,
				directed_rows[i].given, directed_rows[i].want);
		in_ch.valid <= 1'b0;
		drain();

		// All-zero key and nonce, start counter at its low extreme.
		apply_config('0, '0, '0, '0, '0, '0, 32'h0);
		run_phase(120, 70, 1'b1);

		send_idle_pct = 86;
		apply_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom);
		run_phase(150, 0, 1'b0);

		// All-ones registers; a long first message wraps the block counter.
		send_idle_pct  = 0;
		sink_stall_pct = 86;
		apply_config('1, '1, '1, '1, '1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		run_phase(150, 130, 1'b1);

		// Change key and nonce in the middle of a message.
		send_idle_pct  = 12;
		sink_stall_pct = 12;
		write_reg(REG_KEY23, {$urandom, $urandom});
		write_reg(REG_NONCE_HIGH, {32'h0, 32'($urandom)});
		write_reg(REG_START_CTR, {32'h0, 32'h7FFF_FFFF});
		run_phase(150, 100, 1'b0);

		// Hold the output off while the input keeps offering.
		send_idle_pct  = 0;
		sink_stall_pct = 0;
		apply_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom}, $urandom, 32'hFFFF_FFFE);
		hold_requests++;
		run_phase(150, 140, 1'b1);

		send_idle_pct  = 12;
		sink_stall_pct = 12;
		apply_config({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			{$urandom, $urandom}, {$urandom, $urandom}, $urandom, $urandom);
		run_phase(180, 0, 1'b0);

		sink_stall_pct = 0;
		drain();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("run: %0d bytes in, %0d bytes out, %0d message starts, %0d register writes",
			bytes_in, bytes_out, msgs_started, cfg_writes);
		$display("run: %0d mismatches across counter wrap, mid-message rekey and backpressure",
			mismatches);
		if (mismatches == 0)
			$display("** chacha20_stream_xor_unit: PASSED **");
		else
			$display("** chacha20_stream_xor_unit: FAILED **");
		$finish;
	end

endmodule
